@@ sv/ipd_request_uri_parser_macros.svh @@
// Assertion macros for the URI parser checker
`ifndef IPD_REQUEST_URI_PARSER_MACROS_SVH
`define IPD_REQUEST_URI_PARSER_MACROS_SVH

// same-cycle implication, off while in reset
`define IPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipd parser check failed");

// next-cycle implication, off while in reset
`define IPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipd parser check failed");

`endif

@@ sv/ipd_uri_pkg.sv @@
// Package: constants, state codes and result type of the URI parser
package ipd_uri_pkg;

    localparam int MAX_URI = 64;
    localparam int CNT_W   = $clog2(MAX_URI + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;

    localparam int TAG_LEN = 3;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TAG  = 3'd1;
    localparam logic [2:0] ST_ID   = 3'd2;
    localparam logic [2:0] ST_LEN  = 3'd3;
    localparam logic [2:0] ST_VERB = 3'd4;
    localparam logic [2:0] ST_URI  = 3'd5;

    localparam int RES_W = 24;

    typedef struct packed {
        logic       uri_overflow;
        logic [6:0] uri_length;
        logic       request_done;
        logic [5:0] uri_index;
        logic [7:0] uri_byte;
        logic       uri_byte_valid;
    } t_result;

endpackage

@@ sv/ipd_uri_core.sv @@
// Parser state machine: updates state per byte and forms its result
module ipd_uri_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_rx_byte,
    output ipd_uri_pkg::t_result o_res
);

    logic [2:0]                    r_state, n_state;
    logic [ipd_uri_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]                    r_tag [ipd_uri_pkg::TAG_LEN];
    logic [7:0]                    n_tag [ipd_uri_pkg::TAG_LEN];
    logic                          r_ovf, n_ovf;
    logic                          tag_ok;
    logic [ipd_uri_pkg::CNT_W+6:0] cnt_ext;

    assign tag_ok  = (r_tag[0] == ipd_uri_pkg::CH_I) && (r_tag[1] == ipd_uri_pkg::CH_P) &&
                     (r_tag[2] == ipd_uri_pkg::CH_D);
    assign cnt_ext = {7'd0, r_cnt};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_tag   = r_tag;
        n_ovf   = r_ovf;
        o_res   = '0;
        case (r_state)
            ipd_uri_pkg::ST_IDLE: begin
                if (i_rx_byte == ipd_uri_pkg::CH_PLUS) begin
                    n_state = ipd_uri_pkg::ST_TAG;
                    n_cnt   = '0;
                end
            end
            ipd_uri_pkg::ST_TAG: begin
                if (i_rx_byte == ipd_uri_pkg::CH_COMMA ||
                    r_cnt >= ipd_uri_pkg::CNT_W'(ipd_uri_pkg::TAG_LEN)) begin
                    n_cnt   = '0;
                    n_state = tag_ok ? ipd_uri_pkg::ST_ID : ipd_uri_pkg::ST_IDLE;
                end else begin
                    n_tag[r_cnt[1:0]] = i_rx_byte;
                    n_cnt             = r_cnt + 1'b1;
                end
            end
            ipd_uri_pkg::ST_ID: begin
                if (i_rx_byte == ipd_uri_pkg::CH_COMMA) begin
                    n_state = ipd_uri_pkg::ST_LEN;
                end
            end
            ipd_uri_pkg::ST_LEN: begin
                if (i_rx_byte == ipd_uri_pkg::CH_COLON) begin
                    n_state = ipd_uri_pkg::ST_VERB;
                end
            end
            ipd_uri_pkg::ST_VERB: begin
                if (i_rx_byte == ipd_uri_pkg::CH_SLASH) begin
                    n_state = ipd_uri_pkg::ST_URI;
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                end
            end
            ipd_uri_pkg::ST_URI: begin
                if (i_rx_byte == ipd_uri_pkg::CH_SPACE) begin
                    o_res.request_done = 1'b1;
                    o_res.uri_length   = cnt_ext[6:0];
                    o_res.uri_overflow = r_ovf;
                    n_state            = ipd_uri_pkg::ST_IDLE;
                    n_cnt              = '0;
                    n_ovf              = 1'b0;
                end else if (r_cnt < ipd_uri_pkg::CNT_W'(ipd_uri_pkg::MAX_URI)) begin
                    o_res.uri_byte_valid = 1'b1;
                    o_res.uri_byte       = i_rx_byte;
                    o_res.uri_index      = cnt_ext[5:0];
                    n_cnt                = r_cnt + 1'b1;
                end else begin
                    o_res.uri_overflow = 1'b1;
                    n_ovf              = 1'b1;
                end
            end
            default: begin
                n_state = ipd_uri_pkg::ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipd_uri_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_tag   <= '{default: 8'd0};
            r_ovf   <= 1'b0;
        end else if (i_take) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_tag   <= n_tag;
            r_ovf   <= n_ovf;
        end
    end

endmodule

@@ sv/ipd_uri_outreg.sv @@
// Result register: holds one result until the downstream side takes it
module ipd_uri_outreg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ipd_uri_pkg::t_result i_res,
    input  logic                 i_ready,
    output logic                 o_free,
    output logic                 o_valid,
    output ipd_uri_pkg::t_result o_res
);

    logic                 r_valid;
    ipd_uri_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ sv/ipd_request_uri_parser.sv @@
// Top level: +IPD request URI parser, one received byte in, one result out
// Each result is registered and appears in the cycle after its byte transfer.
// Throughput: one byte per cycle; the single result register refills in the
// cycle it is emptied, so back-pressure stalls input only while it is full.
// Reset: i_rst_n is synchronous, active low; parser returns to idle, tag
// bytes clear, result register empties.
module ipd_request_uri_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] uri_byte_valid, [8:1] uri_byte, [14:9] uri_index, [15] request_done,
    // [22:16] uri_length, [23] uri_overflow
    output logic [ipd_uri_pkg::RES_W-1:0] o_m_axis_tdata
);

    logic                 take;
    logic                 free;
    ipd_uri_pkg::t_result core_res;
    ipd_uri_pkg::t_result out_res;

    assign o_s_axis_tready = free;
    assign take            = i_s_axis_tvalid && free;
    assign o_m_axis_tdata  = out_res;

    ipd_uri_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_s_axis_tdata),
        .o_res     (core_res)
    );

    ipd_uri_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_res   (core_res),
        .i_ready (i_m_axis_tready),
        .o_free  (free),
        .o_valid (o_m_axis_tvalid),
        .o_res   (out_res)
    );

endmodule

@@ sv/ipd_uri_chk.sv @@
// Port checker for the URI parser and its bind to the top level
`include "ipd_request_uri_parser_macros.svh"

module ipd_uri_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata
);

    logic in_xfer;

    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    `IPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata))
    `IPD_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_xfer, o_m_axis_tvalid)
    `IPD_ASSERT_NOW(a_byte_or_done, i_clk, i_rst_n, o_m_axis_tvalid,
        !(o_m_axis_tdata[0] && o_m_axis_tdata[15]))
    `IPD_ASSERT_NOW(a_idle_fields_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[0],
        o_m_axis_tdata[8:1] == 8'd0 && o_m_axis_tdata[14:9] == 6'd0)
    `IPD_ASSERT_NOW(a_length_on_done, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[15],
        o_m_axis_tdata[22:16] == 7'd0 && (o_m_axis_tdata[16] == 1'b0 || o_m_axis_tdata[15]))

endmodule

bind ipd_request_uri_parser ipd_uri_chk u_ipd_uri_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

@@ dv/ipd_uri_checker.sv @@
// Checker for the +IPD request URI parser: predicts each result and compares transfers
module ipd_uri_checker
    import ipd_uri_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    input  logic             i_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,   // [7:0] rx_byte
    input  logic             i_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // [0] uri_byte_valid, [8:1] uri_byte, [14:9] uri_index, [15] request_done,
    // [22:16] uri_length, [23] uri_overflow
    input  logic [RES_W-1:0] i_m_axis_tdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_requests,
    output int               o_dropped
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2:0] parse_state;
    logic [6:0] field_count;
    logic [7:0] tag_bytes [TAG_LEN];
    logic       overflow_seen;

    t_result    uri_results [$];
    int         fails;
    int         requests;
    int         dropped;

    initial begin
        fails        = 0;
        requests     = 0;
        dropped      = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_requests   = 0;
        o_dropped    = 0;
    end

    function automatic t_result parse_byte(input logic [7:0] rx);
        t_result r;
        r = '0;
        case (parse_state)
            ST_IDLE: begin
                if (rx == CH_PLUS) begin
                    parse_state = ST_TAG;
                    field_count = '0;
                end
            end
            ST_TAG: begin
                if (rx == CH_COMMA || field_count >= TAG_LEN) begin
                    field_count = '0;
                    parse_state = (tag_bytes[0] == CH_I && tag_bytes[1] == CH_P &&
                                   tag_bytes[2] == CH_D) ? ST_ID : ST_IDLE;
                end else begin
                    tag_bytes[field_count[1:0]] = rx;
                    field_count++;
                end
            end
            ST_ID: begin
                if (rx == CH_COMMA) parse_state = ST_LEN;
            end
            ST_LEN: begin
                if (rx == CH_COLON) parse_state = ST_VERB;
            end
            ST_VERB: begin
                if (rx == CH_SLASH) begin
                    parse_state   = ST_URI;
                    field_count   = '0;
                    overflow_seen = 1'b0;
                end
            end
            ST_URI: begin
                if (rx == CH_SPACE) begin
                    r.request_done = 1'b1;
                    r.uri_length   = field_count;
                    r.uri_overflow = overflow_seen;
                    parse_state    = ST_IDLE;
                    field_count    = '0;
                    overflow_seen  = 1'b0;
                end else if (field_count < MAX_URI) begin
                    r.uri_byte_valid = 1'b1;
                    r.uri_byte       = rx;
                    r.uri_index      = field_count[5:0];
                    field_count++;
                end else begin
                    overflow_seen  = 1'b1;
                    r.uri_overflow = 1'b1;
                end
            end
            default: begin
                parse_state = ST_IDLE;
                field_count = '0;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            parse_state   = ST_IDLE;
            field_count   = '0;
            overflow_seen = 1'b0;
            foreach (tag_bytes[i]) tag_bytes[i] = '0;
            uri_results.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_result'(i_m_axis_tdata);
                if (uri_results.size() == 0) begin
                    $display("%0t ns: unexpected result transfer, expected none, actual 0x%0h",
                             $time, i_m_axis_tdata);
                    fails++;
                end else begin
                    want = uri_results.pop_front();
                    check_field("uri_byte_valid", want.uri_byte_valid, got.uri_byte_valid);
                    check_field("uri_byte", want.uri_byte, got.uri_byte);
                    check_field("uri_index", want.uri_index, got.uri_index);
                    check_field("request_done", want.request_done, got.request_done);
                    check_field("uri_length", want.uri_length, got.uri_length);
                    check_field("uri_overflow", want.uri_overflow, got.uri_overflow);
                    if (want.request_done) requests++;
                    if (want.uri_overflow && !want.request_done) dropped++;
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                uri_results.push_back(parse_byte(i_s_axis_tdata));
            end
        end
        o_pending    <= uri_results.size();
        o_fail_count <= fails;
        o_requests   <= requests;
        o_dropped    <= dropped;
    end

endmodule

@@ dv/tb.sv @@
// Testbench top: byte stimulus, reset, output back-pressure and verdict for the URI parser
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ipd_uri_pkg::*;

    typedef enum int {
        TAG_IPD,
        TAG_FOURTH,
        TAG_STALE,
        TAG_SHORT,
        TAG_MANGLED
    } t_tag_form;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [7:0]       i_s_axis_tdata;   // [7:0] rx_byte
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    // [0] uri_byte_valid, [8:1] uri_byte, [14:9] uri_index, [15] request_done,
    // [22:16] uri_length, [23] uri_overflow
    logic [RES_W-1:0] o_m_axis_tdata;

    int               fail_count;
    int               pending;
    int               requests;
    int               dropped;
    logic [7:0]       rx_stream [$];

    ipd_request_uri_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    ipd_uri_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_requests      (requests),
        .o_dropped       (dropped)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic add_request(input t_tag_form form, input int uri_len, input bit cut_short);
        logic [7:0] req [$];
        logic [7:0] ub;
        string      verb;
        int         drop;
        verb = ":GET /";
        case (form)
            TAG_IPD:     req = {CH_PLUS, CH_I, CH_P, CH_D, CH_COMMA};
            TAG_FOURTH:  req = {CH_PLUS, CH_I, CH_P, CH_D, 8'($urandom)};
            TAG_STALE:   req = {CH_PLUS, CH_COMMA};
            TAG_SHORT:   req = {CH_PLUS, CH_I, CH_P, CH_COMMA};
            default:     req = {CH_PLUS, 8'($urandom), CH_P, 8'($urandom), CH_COMMA};
        endcase
        req.push_back(8'h30 + 8'($urandom_range(0, 9)));
        req.push_back(CH_COMMA);
        repeat ($urandom_range(1, 2)) req.push_back(8'h30 + 8'($urandom_range(0, 9)));
        for (int i = 0; i < verb.len(); i++) req.push_back(verb[i]);
        repeat (uri_len) begin
            do ub = 8'($urandom); while (ub == CH_SPACE);
            req.push_back(ub);
        end
        req.push_back(CH_SPACE);
        if (cut_short) begin
            drop = $urandom_range(1, req.size() - 1);
            repeat (drop) void'(req.pop_back());
        end
        rx_stream = {rx_stream, req};
    endtask

    function automatic int pick_uri_len();
        return ($urandom_range(0, 6) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 12);
    endfunction

    initial begin : receiver
        int unsigned tick;
        logic [7:0]  stall_mask;
        tick            = 0;
        stall_mask      = 8'b1011_0110;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            case ((tick / 200) % 4)
                0:       i_m_axis_tready <= 1'b1;
                1:       i_m_axis_tready <= stall_mask[tick % 8];
                2:       i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: i_m_axis_tready <= 1'($urandom_range(0, 1));
            endcase
            tick++;
        end
    end

    initial begin : stimulus
        int pick;
        int burst;
        int gap;
        int n_bytes;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;

        rx_stream = {CH_PLUS, CH_I, CH_P, CH_D, CH_COMMA, 8'h31, CH_COMMA, 8'h32, CH_COLON,
                     CH_SLASH, 8'h00, 8'hFF, CH_SPACE,
                     CH_PLUS, CH_COMMA, CH_COMMA, CH_COLON, CH_SLASH, CH_SPACE,
                     CH_PLUS, CH_I, CH_P, 8'h51, CH_COMMA};
        n_bytes = rx_stream.size();
        while (rx_stream.size() < n_bytes + 400) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                add_request(TAG_IPD, pick_uri_len(), 1'b0);
            end else if (pick == 5) begin
                add_request(t_tag_form'($urandom_range(0, 4)), pick_uri_len(), 1'b0);
            end else if (pick == 6) begin
                add_request(TAG_IPD, pick_uri_len(), 1'b1);
            end else if (pick == 7) begin
                add_request(t_tag_form'($urandom_range(0, 4)), pick_uri_len(), 1'b1);
            end else begin
                repeat ($urandom_range(1, 8)) rx_stream.push_back(8'($urandom));
            end
        end
        n_bytes = rx_stream.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        while (rx_stream.size() > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && rx_stream.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= rx_stream[0];
                @(posedge i_clk);
                while (!o_s_axis_tready) @(posedge i_clk);
                void'(rx_stream.pop_front());
                burst--;
                @(negedge i_clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 || rx_stream.size() == 0) begin
                i_s_axis_tvalid <= 1'b0;
                i_s_axis_tdata  <= 8'($urandom);
                repeat (gap) @(negedge i_clk);
            end
        end

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Sent %0d bytes: %0d requests completed, %0d URI bytes dropped on overflow.",
                 n_bytes, requests, dropped);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
